@@ rtl/core/transport_server_connection_table_macros.svh @@
`ifndef TRANSPORT_SERVER_CONNECTION_TABLE_MACROS_SVH
`define TRANSPORT_SERVER_CONNECTION_TABLE_MACROS_SVH

// same-cycle implication
`define TSCT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TSCT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/tsct_pkg.sv @@
package tsct_pkg;

  typedef enum logic [2:0] {
    ACT_OPEN    = 3'd0,
    ACT_LISTEN  = 3'd1,
    ACT_CLOSE   = 3'd2,
    ACT_SEGMENT = 3'd3,
    ACT_READ    = 3'd4,
    ACT_TICK    = 3'd5
  } action_t;

  localparam logic [2:0] SEG_SYN  = 3'd0;
  localparam logic [2:0] SEG_FIN  = 3'd2;
  localparam logic [2:0] SEG_DATA = 3'd4;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_REFUSED = 2'd1;
  localparam logic [1:0] STAT_WAITS   = 2'd2;
  localparam logic [1:0] STAT_DROPPED = 2'd3;

  localparam logic [1:0] REP_SYNACK  = 2'd0;
  localparam logic [1:0] REP_FINACK  = 2'd1;
  localparam logic [1:0] REP_DATAACK = 2'd2;

  typedef enum logic [1:0] {
    LINK_CLOSED = 2'd0,
    LINK_LISTEN = 2'd1,
    LINK_CONN   = 2'd2,
    LINK_CWAIT  = 2'd3
  } link_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC
  } seq_state_t;

  typedef struct packed {
    logic [15:0] bound_port;
    link_t       link;
    logic [15:0] client_port;
    logic [31:0] expected_seq;
    logic [15:0] fill;
    logic [19:0] count;
  } entry_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  socket_id;
    logic [15:0] port;
    logic [2:0]  seg_type;
    logic [15:0] peer_port;
    logic [31:0] seq_num;
    logic [15:0] byte_count;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  new_socket;
    logic [1:0]  conn_state;
    logic        reply_valid;
    logic [1:0]  reply_type;
    logic [15:0] reply_src_port;
    logic [15:0] reply_dest_port;
    logic [31:0] reply_ack_num;
    logic [12:0] buffer_offset;
  } result_t;

endpackage

@@ rtl/core/tsct_ram.sv @@
module tsct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [AW-1:0]        raddr,
  output logic [WIDTH-1:0]     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/tsct_engine.sv @@
`include "transport_server_connection_table_macros.svh"

module tsct_engine import tsct_pkg::*; #(
  parameter int CONNECTIONS = 8,
  parameter int BUF_BYTES   = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req_in,
  input  logic [19:0] ticks,
  output logic        res_valid,
  input  logic        res_ready,
  output result_t     res
);
  localparam int IW = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
  localparam logic [IW-1:0] LAST = IW'(CONNECTIONS - 1);

  seq_state_t state, state_next;
  req_t       req;
  logic [IW-1:0] scan_addr, rd_idx;
  logic       issued_all, rd_vld;
  logic       hit, free_found;
  logic [IW-1:0] hit_idx, free_idx;
  entry_t     hit_ent, sid_ent, rd_ent, tick_ent, exec_ent;
  logic [CONNECTIONS-1:0] used, running;
  logic [$bits(entry_t)-1:0] rd_bits, wr_bits;

  logic       accept, fire, tick_we, tick_expire;
  logic       exec_we, used_set, used_clr, run_set, run_clr;
  logic [IW-1:0] exec_idx, wr_addr, sid_idx;
  logic       sid_ok, rep_v;
  logic [1:0] rep_kind;

  tsct_ram #(.WIDTH($bits(entry_t)), .DEPTH(CONNECTIONS)) u_ram (
    .clk   (clk),
    .we    (tick_we || (exec_we && fire)),
    .waddr (wr_addr),
    .wdata (wr_bits),
    .raddr (scan_addr),
    .rdata (rd_bits)
  );

  assign rd_ent    = entry_t'(rd_bits);
  assign accept    = req_valid && req_ready;
  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_EXEC);
  assign fire      = res_valid && res_ready;
  assign sid_idx   = IW'(req.socket_id);
  assign sid_ok    = (32'(req.socket_id) < 32'(CONNECTIONS)) && used[sid_idx];

  // close-wait countdown for the entry coming out of the memory
  always_comb begin
    tick_ent    = rd_ent;
    tick_expire = (rd_ent.count <= 20'd1);
    if (tick_expire) begin
      tick_ent.count        = '0;
      tick_ent.link         = LINK_CLOSED;
      tick_ent.client_port  = '0;
      tick_ent.expected_seq = '0;
    end else begin
      tick_ent.count = rd_ent.count - 20'd1;
    end
  end

  assign tick_we = (state == S_SCAN) && rd_vld && (req.action == ACT_TICK) && running[rd_idx];
  assign wr_addr = tick_we ? rd_idx : exec_idx;
  assign wr_bits = tick_we ? tick_ent : exec_ent;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_SCAN;
      S_SCAN:  if (rd_vld && rd_idx == LAST) state_next = S_EXEC;
      S_EXEC:  if (res_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      scan_addr  <= '0;
      issued_all <= 1'b0;
      rd_vld     <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      used       <= '0;
      running    <= '0;
    end else begin
      state  <= state_next;
      rd_vld <= (state == S_SCAN) && !issued_all;
      if (accept) begin
        scan_addr  <= '0;
        issued_all <= 1'b0;
        hit        <= 1'b0;
        free_found <= 1'b0;
      end else if (state == S_SCAN && !issued_all) begin
        if (scan_addr == LAST) begin
          issued_all <= 1'b1;
        end else begin
          scan_addr <= scan_addr + IW'(1);
        end
      end
      if (state == S_SCAN && rd_vld) begin
        if (used[rd_idx] && rd_ent.bound_port == req.port && !hit) begin
          hit <= 1'b1;
        end
        if (!used[rd_idx] && !free_found) begin
          free_found <= 1'b1;
        end
      end
      if (tick_we && tick_expire) begin
        running[rd_idx] <= 1'b0;
      end
      if (fire) begin
        if (used_set) used[exec_idx] <= 1'b1;
        if (used_clr) used[exec_idx] <= 1'b0;
        if (run_set)  running[exec_idx] <= 1'b1;
        if (run_clr)  running[exec_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= req_in;
    end
    if (state == S_SCAN && !issued_all) begin
      rd_idx <= scan_addr;
    end
    if (state == S_SCAN && rd_vld) begin
      if (used[rd_idx] && rd_ent.bound_port == req.port && !hit) begin
        hit_idx <= rd_idx;
        hit_ent <= rd_ent;
      end
      if (!used[rd_idx] && !free_found) begin
        free_idx <= rd_idx;
      end
      if (32'(rd_idx) == 32'(req.socket_id)) begin
        sid_ent <= tick_we ? tick_ent : rd_ent;
      end
    end
  end

  always_comb begin
    res      = '0;
    res.status = STAT_REFUSED;
    exec_ent = sid_ent;
    exec_idx = sid_idx;
    exec_we  = 1'b0;
    used_set = 1'b0;
    used_clr = 1'b0;
    run_set  = 1'b0;
    run_clr  = 1'b0;
    rep_v    = 1'b0;
    rep_kind = REP_SYNACK;
    case (req.action)
      ACT_OPEN: begin
        exec_idx = free_idx;
        if (!hit && free_found) begin
          exec_ent             = '0;
          exec_ent.bound_port  = req.port;
          exec_we              = 1'b1;
          used_set             = 1'b1;
          run_clr              = 1'b1;
          res.status           = STAT_OK;
          res.new_socket       = 3'(free_idx);
        end
      end
      ACT_LISTEN: begin
        if (sid_ok && sid_ent.link == LINK_CLOSED) begin
          exec_ent.link = LINK_LISTEN;
          exec_we       = 1'b1;
          res.status    = STAT_OK;
        end
        res.conn_state = sid_ok ? exec_ent.link : LINK_CLOSED;
      end
      ACT_CLOSE: begin
        if (sid_ok && sid_ent.link == LINK_CLOSED) begin
          used_clr   = 1'b1;
          run_clr    = 1'b1;
          res.status = STAT_OK;
        end
        // a refused close still reports the entry's state
        res.conn_state = sid_ok ? sid_ent.link : LINK_CLOSED;
      end
      ACT_SEGMENT: begin
        res.status = STAT_DROPPED;
        exec_ent   = hit_ent;
        exec_idx   = hit_idx;
        if (hit) begin
          if (hit_ent.link == LINK_LISTEN) begin
            if (req.seg_type == SEG_SYN) begin
              exec_ent.link         = LINK_CONN;
              exec_ent.client_port  = req.peer_port;
              exec_ent.expected_seq = req.seq_num;
              exec_we    = 1'b1;
              res.status = STAT_OK;
              rep_v      = 1'b1;
              rep_kind   = REP_SYNACK;
            end
          end else if (hit_ent.link == LINK_CONN && req.peer_port == hit_ent.client_port) begin
            if (req.seg_type == SEG_SYN) begin
              res.status = STAT_OK;
              rep_v      = 1'b1;
              rep_kind   = REP_SYNACK;
            end else if (req.seg_type == SEG_DATA) begin
              res.buffer_offset = 13'(hit_ent.fill);
              if (req.seq_num == hit_ent.expected_seq &&
                  ({1'b0, hit_ent.fill} + {1'b0, req.byte_count}) <= 17'(BUF_BYTES)) begin
                exec_ent.fill         = hit_ent.fill + req.byte_count;
                exec_ent.expected_seq = hit_ent.expected_seq + 32'(req.byte_count);
                exec_we    = 1'b1;
                res.status = STAT_OK;
              end
              rep_v    = 1'b1;
              rep_kind = REP_DATAACK;
            end else if (req.seg_type == SEG_FIN) begin
              exec_ent.link  = LINK_CWAIT;
              exec_ent.count = ticks;
              exec_we    = 1'b1;
              run_set    = 1'b1;
              res.status = STAT_OK;
              rep_v      = 1'b1;
              rep_kind   = REP_FINACK;
            end
          end else if (hit_ent.link == LINK_CWAIT && req.peer_port == hit_ent.client_port &&
                       req.seg_type == SEG_FIN) begin
            res.status = STAT_OK;
            rep_v      = 1'b1;
            rep_kind   = REP_FINACK;
          end
          res.conn_state = exec_ent.link;
        end else begin
          // no bound port: the socket_id entry is reported
          res.conn_state = sid_ok ? sid_ent.link : LINK_CLOSED;
        end
        if (rep_v) begin
          res.reply_valid     = 1'b1;
          res.reply_type      = rep_kind;
          res.reply_src_port  = exec_ent.bound_port;
          res.reply_dest_port = exec_ent.client_port;
          res.reply_ack_num   = exec_ent.expected_seq;
        end
      end
      ACT_READ: begin
        if (sid_ok && sid_ent.link == LINK_CONN) begin
          if (req.byte_count <= sid_ent.fill) begin
            exec_ent.fill = sid_ent.fill - req.byte_count;
            exec_we       = 1'b1;
            res.status    = STAT_OK;
          end else begin
            res.status = STAT_WAITS;
          end
        end
        res.conn_state = sid_ok ? sid_ent.link : LINK_CLOSED;
      end
      ACT_TICK: begin
        res.status     = STAT_OK;
        res.conn_state = sid_ok ? sid_ent.link : LINK_CLOSED;
      end
      default: begin
        res.conn_state = sid_ok ? sid_ent.link : LINK_CLOSED;
      end
    endcase
  end

  `TSCT_ASSERT_IMP(a_write_window, clk, rst, tick_we || (exec_we && fire),
    state == S_SCAN || state == S_EXEC, "table written outside scan or execute")
  `TSCT_ASSERT_NXT(a_accept_scan, clk, rst, accept, state == S_SCAN,
    "request accepted without starting the sweep")
  `TSCT_ASSERT_NXT(a_done_idle, clk, rst, fire, state == S_IDLE,
    "result handed off but sequencer not idle")
  `TSCT_ASSERT_IMP(a_tick_only, clk, rst, tick_we, req.action == ACT_TICK,
    "countdown write during a non-tick request")
endmodule

@@ rtl/core/transport_server_connection_table.sv @@
// server-side connection table for a simple reliable transport
// s_axis request: s_tuser carries the action code, s_tdata the operands
// m_axis response: one result per request with status, connection state
// and the acknowledgement reply fields, if any
// cfg_we / cfg_wdata write the close-wait tick count (reset value 1000);
// write it only while no request is in flight
// every request sweeps the connection memory one entry per cycle, so a
// request takes CONNECTIONS + 2 cycles from acceptance to the output
// register, and a new request is taken every CONNECTIONS + 3 cycles
// reset empties the table at once through per-entry used bits; the
// memory itself needs no clearing
// a stalled m_axis holds its result in the output register; the next
// request is still accepted and swept, and waits before its result
module transport_server_connection_table import tsct_pkg::*; #(
  parameter int CONNECTIONS = 8,
  parameter int BUF_BYTES   = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // socket_id, port, seg_type, peer_port, seq_num, byte_count, zero pad
  input  logic [87:0] s_tdata,
  // action
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status, new_socket, conn_state, reply_valid, reply_type,
  // reply_src_port, reply_dest_port, reply_ack_num, buffer_offset, zero pad
  output logic [87:0] m_tdata,
  input  logic        cfg_we,
  input  logic [19:0] cfg_wdata
);
  logic [19:0] closewait_ticks;
  req_t        req;
  result_t     res;
  logic        res_valid, res_ready;

  assign req = {s_tuser, s_tdata[2:0], s_tdata[18:3], s_tdata[21:19], s_tdata[37:22],
                s_tdata[69:38], s_tdata[85:70]};

  always_ff @(posedge clk) begin
    if (rst) begin
      closewait_ticks <= 20'd1000;
    end else if (cfg_we) begin
      closewait_ticks <= cfg_wdata;
    end
  end

  tsct_engine #(.CONNECTIONS(CONNECTIONS), .BUF_BYTES(BUF_BYTES)) u_engine (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .req_in    (req),
    .ticks     (closewait_ticks),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {1'b0, res.buffer_offset, res.reply_ack_num, res.reply_dest_port,
                  res.reply_src_port, res.reply_type, res.reply_valid, res.conn_state,
                  res.new_socket, res.status};
    end
  end
endmodule

@@ tb/tb_transport_server_connection_table.sv @@
module tb_transport_server_connection_table import tsct_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCONN = 8;
  localparam int BUFSZ = 4096;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  socket_id;
    logic [15:0] port;
    logic [2:0]  seg_type;
    logic [15:0] peer_port;
    logic [31:0] seq_num;
    logic [15:0] byte_count;
  } request_t;

  localparam int RQW = $bits(request_t);

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  new_socket;
    logic [1:0]  conn_state;
    logic        reply_valid;
    logic [1:0]  reply_type;
    logic [15:0] reply_src_port;
    logic [15:0] reply_dest_port;
    logic [31:0] reply_ack_num;
    logic [12:0] buffer_offset;
  } answer_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [87:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [87:0] m_tdata;
  logic        cfg_we;
  logic [19:0] cfg_wdata;

  transport_server_connection_table DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // table mirror
  logic [19:0] cw_ticks;
  logic        t_used [NCONN];
  logic [15:0] t_sport [NCONN];
  link_t       t_link [NCONN];
  logic [15:0] t_cport [NCONN];
  logic [31:0] t_seq [NCONN];
  logic [12:0] t_fill [NCONN];
  logic [19:0] t_cnt [NCONN];
  logic        t_run [NCONN];

  request_t pending_q[$];
  answer_t  answer_q[$];
  int       errors;
  int       cycles;
  int       src_idle;
  int       snk_idle;
  int       hold_off;
  bit       calm;
  bit       src_pause;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void table_reset();
    cw_ticks = 20'd1000;
    for (int i = 0; i < NCONN; i++) begin
      wipe_entry(i);
    end
  endfunction

  function automatic void wipe_entry(int i);
    t_used[i] = 1'b0;
    t_sport[i] = '0;
    t_link[i] = LINK_CLOSED;
    t_cport[i] = '0;
    t_seq[i] = '0;
    t_fill[i] = '0;
    t_cnt[i] = '0;
    t_run[i] = 1'b0;
  endfunction

  function automatic int port_lookup(logic [15:0] p);
    for (int i = 0; i < NCONN; i++) begin
      if (t_used[i] && t_sport[i] == p) return i;
    end
    return -1;
  endfunction

  function automatic answer_t predict_answer(request_t r);
    answer_t a;
    int m;
    int s;
    bit done;
    logic [16:0] sum;
    a = '0;
    a.status = STAT_REFUSED;
    s = r.socket_id;
    done = 0;
    case (r.action)
      ACT_OPEN: begin
        if (port_lookup(r.port) < 0) begin
          for (int i = 0; i < NCONN; i++) begin
            if (!done && !t_used[i]) begin
              wipe_entry(i);
              t_used[i] = 1'b1;
              t_sport[i] = r.port;
              a.status = STAT_OK;
              a.new_socket = i[2:0];
              done = 1;
            end
          end
        end
      end
      ACT_LISTEN: begin
        if (t_used[s] && t_link[s] == LINK_CLOSED) begin
          t_link[s] = LINK_LISTEN;
          a.status = STAT_OK;
        end
      end
      ACT_CLOSE: begin
        if (t_used[s] && t_link[s] == LINK_CLOSED) begin
          wipe_entry(s);
          a.status = STAT_OK;
        end
      end
      ACT_SEGMENT: begin
        m = port_lookup(r.port);
        a.status = STAT_DROPPED;
        // with no bound port the socket_id entry is reported below
        if (m >= 0) begin
          if (t_link[m] == LINK_LISTEN) begin
            if (r.seg_type == SEG_SYN) begin
              t_link[m] = LINK_CONN;
              t_cport[m] = r.peer_port;
              t_seq[m] = r.seq_num;
              a.status = STAT_OK;
              a.reply_valid = 1'b1;
              a.reply_type = REP_SYNACK;
            end
          end else if (t_link[m] == LINK_CONN && r.peer_port == t_cport[m]) begin
            if (r.seg_type == SEG_SYN) begin
              a.status = STAT_OK;
              a.reply_valid = 1'b1;
              a.reply_type = REP_SYNACK;
            end else if (r.seg_type == SEG_DATA) begin
              a.buffer_offset = t_fill[m];
              sum = t_fill[m] + r.byte_count;
              if (r.seq_num == t_seq[m] && sum <= BUFSZ) begin
                t_fill[m] = sum[12:0];
                t_seq[m] = t_seq[m] + r.byte_count;
                a.status = STAT_OK;
              end
              a.reply_valid = 1'b1;
              a.reply_type = REP_DATAACK;
            end else if (r.seg_type == SEG_FIN) begin
              t_link[m] = LINK_CWAIT;
              t_cnt[m] = cw_ticks;
              t_run[m] = 1'b1;
              a.status = STAT_OK;
              a.reply_valid = 1'b1;
              a.reply_type = REP_FINACK;
            end
          end else if (t_link[m] == LINK_CWAIT && r.peer_port == t_cport[m] &&
                       r.seg_type == SEG_FIN) begin
            a.status = STAT_OK;
            a.reply_valid = 1'b1;
            a.reply_type = REP_FINACK;
          end
          if (a.reply_valid) begin
            a.reply_src_port = t_sport[m];
            a.reply_dest_port = t_cport[m];
            a.reply_ack_num = t_seq[m];
          end
          a.conn_state = t_link[m];
          return a;
        end
      end
      ACT_READ: begin
        if (t_used[s] && t_link[s] == LINK_CONN) begin
          if (r.byte_count <= t_fill[s]) begin
            t_fill[s] = 13'(t_fill[s] - r.byte_count);
            a.status = STAT_OK;
          end else begin
            a.status = STAT_WAITS;
          end
        end
      end
      ACT_TICK: begin
        for (int i = 0; i < NCONN; i++) begin
          if (t_run[i]) begin
            if (t_cnt[i] <= 20'd1) begin
              t_run[i] = 1'b0;
              t_cnt[i] = '0;
              t_link[i] = LINK_CLOSED;
              t_cport[i] = '0;
              t_seq[i] = '0;
            end else begin
              t_cnt[i] = t_cnt[i] - 20'd1;
            end
          end
        end
        a.status = STAT_OK;
      end
      default: ;
    endcase
    if (r.action == ACT_OPEN) begin
      a.conn_state = (a.status == STAT_OK) ? t_link[a.new_socket] : LINK_CLOSED;
    end else if (t_used[s]) begin
      a.conn_state = t_link[s];
    end
    return a;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_idle <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (src_idle > 0) begin
        src_idle <= src_idle - 1;
        s_tvalid <= 1'b0;
      end else if (pending_q.size() > 0 && !src_pause) begin
        request_t r;
        r = pending_q.pop_front();
        answer_q.push_back(predict_answer(r));
        s_tuser <= r.action;
        s_tdata <= {2'd0, r.byte_count, r.seq_num, r.peer_port, r.seg_type, r.port,
                    r.socket_id};
        s_tvalid <= 1'b1;
        if (!calm && $urandom_range(0, 9) == 0) src_idle <= $urandom_range(1, 18);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      snk_idle <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        answer_t got;
        answer_t exp;
        got = {m_tdata[1:0], m_tdata[4:2], m_tdata[6:5], m_tdata[7], m_tdata[9:8],
               m_tdata[25:10], m_tdata[41:26], m_tdata[73:42], m_tdata[86:74]};
        if (answer_q.size() == 0) begin
          $display("%0t unexpected response %h", $time, got);
          errors++;
        end else begin
          exp = answer_q.pop_front();
          if (got !== exp) begin
            $display("%0t mismatch expected %h actual %h", $time, exp, got);
            errors++;
          end
        end
      end
      if (hold_off > 0) begin
        m_tready <= 1'b0;
      end else if (snk_idle > 0) begin
        snk_idle <= snk_idle - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!calm && $urandom_range(0, 9) == 0) snk_idle <= $urandom_range(1, 18);
      end
    end
  end

  // long receiver hold-off, counted down here
  always @(posedge clk) begin
    if (hold_off > 0) hold_off <= hold_off - 1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic request_t mk(logic [2:0] act, logic [2:0] sid, logic [15:0] p,
                                  logic [2:0] st, logic [15:0] sp, logic [31:0] sq,
                                  logic [15:0] bc);
    request_t r;
    r.action = act;
    r.socket_id = sid;
    r.port = p;
    r.seg_type = st;
    r.peer_port = sp;
    r.seq_num = sq;
    r.byte_count = bc;
    return r;
  endfunction

  function automatic request_t noise();
    request_t r;
    r = RQW'({$urandom, $urandom, $urandom, $urandom});
    r.port = $urandom_range(0, 3) == 0 ? r.port : 16'(100 + $urandom_range(0, 9));
    return r;
  endfunction

  // one connection life: open, listen, syn, data, reads, fin, ticks, close
  task automatic add_session(logic [15:0] p);
    logic [15:0] cp;
    logic [31:0] sq;
    logic [15:0] n;
    int sid;
    sid = $urandom_range(0, 7);
    cp = 16'($urandom);
    sq = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255) : $urandom;
    pending_q.push_back(mk(ACT_OPEN, 0, p, 0, 0, 0, 0));
    pending_q.push_back(mk(ACT_LISTEN, 3'(sid), 0, 0, 0, 0, 0));
    pending_q.push_back(mk(ACT_SEGMENT, 0, p, SEG_SYN, cp, sq, 0));
    repeat ($urandom_range(1, 6)) begin
      n = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1500));
      if ($urandom_range(0, 5) == 0) begin
        pending_q.push_back(mk(ACT_SEGMENT, 0, p, SEG_DATA, cp, $urandom, n));
      end else begin
        pending_q.push_back(mk(ACT_SEGMENT, 0, p, SEG_DATA, cp, sq, n));
        if (n <= BUFSZ) sq = sq + n;
      end
      if ($urandom_range(0, 2) == 0)
        pending_q.push_back(mk(ACT_READ, 3'(sid), 0, 0, 0, 0, 16'($urandom_range(0, 2000))));
      if ($urandom_range(0, 7) == 0) pending_q.push_back(noise());
    end
    pending_q.push_back(mk(ACT_SEGMENT, 0, p, SEG_FIN, cp, 0, 0));
    repeat ($urandom_range(0, 4)) pending_q.push_back(mk(ACT_TICK, 0, 0, 0, 0, 0, 0));
    if ($urandom_range(0, 1) == 0)
      pending_q.push_back(mk(ACT_CLOSE, 3'(sid), 0, 0, 0, 0, 0));
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || answer_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_ticks(logic [19:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    cw_ticks = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    errors = 0;
    cycles = 0;
    hold_off = 0;
    calm = 0;
    src_pause = 0;
    table_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    write_ticks(20'd2);

    // directed: open / listen / connect / data extremes / fin / timeout
    pending_q.push_back(mk(ACT_OPEN, 0, 16'hFFFF, 0, 0, 0, 0));
    pending_q.push_back(mk(ACT_OPEN, 0, 16'hFFFF, 0, 0, 0, 0));
    pending_q.push_back(mk(ACT_OPEN, 0, 16'h0000, 0, 0, 0, 0));
    pending_q.push_back(mk(ACT_LISTEN, 7, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(ACT_READ, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(ACT_LISTEN, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(ACT_LISTEN, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(ACT_SEGMENT, 0, 16'hFFFF, 3'd4, 16'hFFFF, 0, 0));
    pending_q.push_back(mk(ACT_SEGMENT, 0, 16'hFFFF, SEG_SYN, 16'hFFFF, 32'hFFFF_FFF0, 0));
    pending_q.push_back(mk(ACT_SEGMENT, 0, 16'hFFFF, SEG_SYN, 16'hFFFF, 0, 0));
    pending_q.push_back(mk(ACT_SEGMENT, 0, 16'hFFFF, SEG_DATA, 16'hFFFF, 32'hFFFF_FFF0,
                           16'd4000));
    pending_q.push_back(mk(ACT_SEGMENT, 0, 16'hFFFF, SEG_DATA, 16'hFFFF, 32'h0000_0F90,
                           16'd96));
    pending_q.push_back(mk(ACT_SEGMENT, 0, 16'hFFFF, SEG_DATA, 16'hFFFF, 32'h0000_0FF0,
                           16'd1));
    pending_q.push_back(mk(ACT_SEGMENT, 0, 16'hFFFF, SEG_DATA, 16'h0001, 32'h0000_0FF0, 0));
    pending_q.push_back(mk(ACT_READ, 0, 0, 0, 0, 0, 16'hFFFF));
    pending_q.push_back(mk(ACT_READ, 0, 0, 0, 0, 0, 16'd4096));
    pending_q.push_back(mk(ACT_SEGMENT, 0, 16'hFFFF, SEG_FIN, 16'hFFFF, 0, 0));
    pending_q.push_back(mk(ACT_SEGMENT, 0, 16'hFFFF, SEG_FIN, 16'hFFFF, 0, 0));
    pending_q.push_back(mk(ACT_CLOSE, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(ACT_TICK, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(ACT_TICK, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(ACT_CLOSE, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(3'd6, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(3'd7, 7, 16'hFFFF, 3'd7, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF));
    for (int i = 0; i < 9; i++) pending_q.push_back(mk(ACT_OPEN, 0, 16'(200 + i), 0, 0, 0, 0));
    drain();

    // receiver holds off long while the sender keeps offering
    hold_off = 300;
    for (int i = 0; i < 40; i++) pending_q.push_back(noise());
    drain();
    for (int i = 0; i < NCONN; i++) pending_q.push_back(mk(ACT_CLOSE, 3'(i), 0, 0, 0, 0, 0));
    drain();

    // random sessions, several register settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_ticks(20'd1);
        1: write_ticks(20'd0);
        2: write_ticks(20'd3);
        default: write_ticks(20'hFFFFF);
      endcase
      if (ph == 3) calm = 1;
      while (pending_q.size() < 200) begin
        add_session(16'(100 + $urandom_range(0, 9)));
        if ($urandom_range(0, 3) == 0) pending_q.push_back(noise());
      end
      // part of the batch goes out, then the sender holds until every response is back
      while (pending_q.size() > 100) @(posedge clk);
      src_pause = 1;
      while (answer_q.size() > 0) @(posedge clk);
      src_pause = 0;
      drain();
      if (ph == 3) write_ticks(20'd1000);
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/tsct_pkg.sv
rtl/core/tsct_ram.sv
rtl/core/tsct_engine.sv
rtl/core/transport_server_connection_table.sv
tb/tb_transport_server_connection_table.sv
